@@ rtl/core/sld_pkg.sv @@
// Package for the sync-word, length-prefixed frame deframer.
// Holds the phase type, sync reset value and field widths; no dependencies.
package sld_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SYNC_W     = 32;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned SYNC_BYTES = 4;
    localparam int unsigned SEEN_W     = 3;

    localparam logic [SYNC_W-1:0] SYNC_RESET = 32'h97FA_4613;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_LEN_LO  = 2'd1,
        PH_LEN_HI  = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

endpackage

@@ rtl/core/sync_length_frame_deframer_unit.sv @@
// Top level of the sync-word, length-prefixed frame deframer.
// Depends on sld_pkg for the phase type and constants.

// Takes one received byte per beat and can accept a beat on every clock: the
// per-byte phase update is one step of short logic ending in a single output
// register, and the input is ready whenever that register is empty or is
// being drained in the same cycle. A payload byte passes through the output
// register before it appears on the master side; sync, length and dropped
// bytes give no output beat. sync_word written via cfg_we takes effect on the
// next hunted byte.
module sync_length_frame_deframer_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [sld_pkg::SYNC_W-1:0]   cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sld_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sld_pkg::BYTE_W-1:0]   m_tdata,   // [7:0] payload_byte
    output logic                         m_tuser,   // [0] first_of_frame
    output logic                         m_tlast    // last_of_frame
);

    sld_pkg::phase_t                 phase_reg, phase_next;
    logic [sld_pkg::SYNC_W-1:0]      sync_reg;
    logic [sld_pkg::SYNC_W-1:0]      window_reg, window_next;
    logic [sld_pkg::SEEN_W-1:0]      seen_reg, seen_next;
    logic [sld_pkg::BYTE_W-1:0]      len_lo_reg, len_lo_next;
    logic [sld_pkg::LEN_W-1:0]       remain_reg, remain_next;
    logic                            start_reg, start_next;
    logic                            out_valid_reg, out_valid_next;
    logic [sld_pkg::BYTE_W-1:0]      out_data_reg, out_data_next;
    logic                            out_first_reg, out_first_next;
    logic                            out_last_reg, out_last_next;
    logic                            in_fire;
    logic                            out_fire;
    logic [sld_pkg::LEN_W-1:0]       len_full;

    assign out_fire = out_valid_reg & m_tready;
    assign s_tready = ~out_valid_reg | m_tready;
    assign in_fire  = s_tvalid & s_tready;
    assign len_full = {s_tdata, len_lo_reg};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_first_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= sld_pkg::SYNC_RESET;
        end
        else if (cfg_we)
        begin
            sync_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sld_pkg::PH_HUNT;
            window_reg    <= '0;
            seen_reg      <= '0;
            len_lo_reg    <= '0;
            remain_reg    <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            window_reg    <= window_next;
            seen_reg      <= seen_next;
            len_lo_reg    <= len_lo_next;
            remain_reg    <= remain_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_first_reg <= out_first_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        window_next    = window_reg;
        seen_next      = seen_reg;
        len_lo_next    = len_lo_reg;
        remain_next    = remain_reg;
        start_next     = start_reg;
        out_valid_next = out_valid_reg & ~out_fire;
        out_data_next  = out_data_reg;
        out_first_next = out_first_reg;
        out_last_next  = out_last_reg;
        if (in_fire)
        begin
            unique case (phase_reg)
                sld_pkg::PH_HUNT:
                begin
                    window_next = {window_reg[sld_pkg::SYNC_W-sld_pkg::BYTE_W-1:0], s_tdata};
                    if (seen_reg < sld_pkg::SEEN_W'(sld_pkg::SYNC_BYTES))
                    begin
                        seen_next = seen_reg + 1'b1;
                    end
                    if (seen_next == sld_pkg::SEEN_W'(sld_pkg::SYNC_BYTES)
                        && window_next == sync_reg)
                    begin
                        phase_next = sld_pkg::PH_LEN_LO;
                    end
                end
                sld_pkg::PH_LEN_LO:
                begin
                    len_lo_next = s_tdata;
                    phase_next  = sld_pkg::PH_LEN_HI;
                end
                sld_pkg::PH_LEN_HI:
                begin
                    remain_next = len_full;
                    if (len_full == '0)
                    begin
                        phase_next  = sld_pkg::PH_HUNT;
                        window_next = '0;
                        seen_next   = '0;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        phase_next = sld_pkg::PH_PAYLOAD;
                    end
                end
                sld_pkg::PH_PAYLOAD:
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = s_tdata;
                    out_first_next = start_reg;
                    out_last_next  = (remain_reg <= sld_pkg::LEN_W'(1));
                    start_next     = 1'b0;
                    if (remain_reg <= sld_pkg::LEN_W'(1))
                    begin
                        remain_next = '0;
                        phase_next  = sld_pkg::PH_HUNT;
                        window_next = '0;
                        seen_next   = '0;
                    end
                    else
                    begin
                        remain_next = remain_reg - 1'b1;
                    end
                end
                default:
                begin
                    phase_next = sld_pkg::PH_HUNT;
                end
            endcase
        end
    end

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= sld_pkg::SEEN_W'(sld_pkg::SYNC_BYTES))
        else $error("window fill count overran");

    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == sld_pkg::PH_PAYLOAD |-> remain_reg != '0)
        else $error("payload phase with no bytes left");

    a_out_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && phase_reg != sld_pkg::PH_PAYLOAD && !m_tready && out_valid_reg)
        |=> $stable(m_tdata))
        else $error("non-payload byte disturbed held output");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && phase_reg == sld_pkg::PH_PAYLOAD && remain_reg == sld_pkg::LEN_W'(1))
        |=> (m_tlast && phase_reg == sld_pkg::PH_HUNT && seen_reg == '0))
        else $error("frame end did not return to hunt");

endmodule

@@ sim/sync_length_frame_deframer_unit_tb.sv @@
// Self-checking testbench for the sync-word, length-prefixed frame deframer.
// Predicts payload beats in a scoreboard class and drives the stream ports with plain tasks.
// Depends on sld_pkg and sync_length_frame_deframer_unit.
module sync_length_frame_deframer_unit_tb;

    localparam int unsigned LEAD_NONE        = 0;
    localparam int unsigned LEAD_NOISE       = 1;
    localparam int unsigned LEAD_FALSE_START = 2;

    localparam int unsigned RX_ALWAYS = 0;
    localparam int unsigned RX_RANDOM = 1;

    typedef struct packed {
        logic [sld_pkg::BYTE_W-1:0] data;
        logic                       first;
        logic                       last;
    } payload_beat_t;

    class deframe_scoreboard;
        sld_pkg::phase_t              phase;
        logic [sld_pkg::SYNC_W-1:0]   sync;
        logic [sld_pkg::SYNC_W-1:0]   window;
        int unsigned                  seen;
        logic [sld_pkg::BYTE_W-1:0]   len_low;
        logic [sld_pkg::LEN_W-1:0]    remaining;
        logic                         at_start;
        payload_beat_t                payload_beats[$];
        int unsigned                  errors;

        function new();
            sync      = sld_pkg::SYNC_RESET;
            phase     = sld_pkg::PH_HUNT;
            window    = '0;
            seen      = 0;
            len_low   = '0;
            remaining = '0;
            at_start  = 1'b0;
            errors    = 0;
        endfunction

        function void restart_hunt();
            phase  = sld_pkg::PH_HUNT;
            window = '0;
            seen   = 0;
        endfunction

        function void take_rx_byte(logic [sld_pkg::BYTE_W-1:0] b);
            payload_beat_t beat;
            case (phase)
                sld_pkg::PH_HUNT:
                begin
                    window = {window[sld_pkg::SYNC_W-sld_pkg::BYTE_W-1:0], b};
                    if (seen < sld_pkg::SYNC_BYTES)
                        seen++;
                    if (seen >= sld_pkg::SYNC_BYTES && window == sync)
                        phase = sld_pkg::PH_LEN_LO;
                end
                sld_pkg::PH_LEN_LO:
                begin
                    len_low = b;
                    phase   = sld_pkg::PH_LEN_HI;
                end
                sld_pkg::PH_LEN_HI:
                begin
                    remaining = {b, len_low};
                    if (remaining == 0)
                        restart_hunt();
                    else
                    begin
                        at_start = 1'b1;
                        phase    = sld_pkg::PH_PAYLOAD;
                    end
                end
                default:
                begin
                    beat.data  = b;
                    beat.first = at_start;
                    beat.last  = (remaining <= 1);
                    payload_beats.push_back(beat);
                    at_start = 1'b0;
                    if (remaining <= 1)
                    begin
                        remaining = '0;
                        restart_hunt();
                    end
                    else
                        remaining--;
                end
            endcase
        endfunction

        function void check_payload_beat(logic [sld_pkg::BYTE_W-1:0] data, logic first,
                                         logic last);
            payload_beat_t want;
            if (payload_beats.size() == 0)
            begin
                $error("unexpected payload beat: payload_byte %h", data);
                errors++;
                return;
            end
            want = payload_beats.pop_front();
            if (data !== want.data)
            begin
                $error("payload_byte: expected %h, got %h", want.data, data);
                errors++;
            end
            if (first !== want.first)
            begin
                $error("first_of_frame: expected %0b, got %0b", want.first, first);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_of_frame: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return payload_beats.size();
        endfunction
    endclass

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [sld_pkg::SYNC_W-1:0]    cfg_wdata = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [sld_pkg::BYTE_W-1:0]    s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [sld_pkg::BYTE_W-1:0]    m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;

    deframe_scoreboard    board;
    int unsigned          bytes_sent = 0;
    int unsigned          burst_left = 0;
    int unsigned          stall_left = 0;
    int unsigned          tx_mode    = 0;
    int unsigned          rx_mode    = RX_ALWAYS;

    sync_length_frame_deframer_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        case (rx_mode)
            RX_ALWAYS: m_tready <= 1'b1;
            RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (stall_left != 0)
                begin
                    m_tready   <= 1'b0;
                    stall_left <= stall_left - 1;
                end
                else
                begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        stall_left <= $urandom_range(1, 12);
                end
            end
        endcase
    end

    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_payload_beat(m_tdata, m_tuser, m_tlast);
    end

    task automatic send_byte(input logic [sld_pkg::BYTE_W-1:0] b);
        if (tx_mode != 0 && burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left != 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(negedge clk);
        while (!s_tready);
        board.take_rx_byte(b);
        bytes_sent++;
        @(posedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_sync(input logic [sld_pkg::SYNC_W-1:0] w);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.sync = w;
    endtask

    task automatic send_frame(input logic [sld_pkg::LEN_W-1:0] len, input int unsigned lead_in);
        logic [sld_pkg::SYNC_W-1:0] w;
        int unsigned                k;
        w = board.sync;
        if (lead_in == LEAD_NOISE)
            repeat ($urandom_range(1, 3)) send_byte(sld_pkg::BYTE_W'($urandom_range(0, 255)));
        else if (lead_in == LEAD_FALSE_START && w != {w[15:0], w[15:0]})
        begin
            k = $urandom_range(1, 2);
            for (int i = 0; i < k; i++)
                send_byte(w[8*(3-i) +: 8]);
        end
        for (int i = 0; i < 4; i++)
            send_byte(w[8*(3-i) +: 8]);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_byte(w[8*$urandom_range(0, 3) +: 8]);
            else
                send_byte(sld_pkg::BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        logic [sld_pkg::BYTE_W-1:0] opening[24] = '{
            8'h00, 8'h97, 8'hFA, 8'h46, 8'h13, 8'h01, 8'h00, 8'hFF,
            8'h97, 8'hFA, 8'h46, 8'h13, 8'h00, 8'h00,
            8'h97, 8'hFA, 8'h46, 8'h13, 8'h03, 8'h00, 8'h97, 8'hFA, 8'h46, 8'h13
        };
        logic [sld_pkg::SYNC_W-1:0] next_sync;
        logic [sld_pkg::SYNC_W-1:0] w;
        logic [sld_pkg::LEN_W-1:0]  flen;
        int unsigned                pick;
        int unsigned                k;

        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_byte(opening[i]);

        for (int p = 0; p < 8; p++)
        begin
            drain_results();
            case (p)
                0:       next_sync = 32'h0000_0000;
                1:       next_sync = 32'hFFFF_FFFF;
                2:       next_sync = 32'h0000_005A;
                3:       next_sync = 32'h9797_FA97;
                6:       next_sync = sld_pkg::SYNC_RESET;
                default: next_sync = $urandom;
            endcase
            write_sync(next_sync);
            tx_mode = (p % 3 != 0) ? 1 : 0;
            rx_mode = p % 3;
            // lone last sync byte right after a frame: window matches but is short
            if (p == 2)
            begin
                send_frame(sld_pkg::LEN_W'(1), LEAD_NONE);
                send_byte(next_sync[7:0]);
            end
            while (bytes_sent < 24 + (p + 1) * 204)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 10)
                        flen = '0;
                    else if (pick < 95)
                        flen = sld_pkg::LEN_W'($urandom_range(1, 12));
                    else
                        flen = sld_pkg::LEN_W'($urandom_range(13, 300));
                    send_frame(flen, $urandom_range(LEAD_NONE, LEAD_FALSE_START));
                end
                else if (pick < 90)
                    repeat ($urandom_range(1, 8))
                        send_byte(sld_pkg::BYTE_W'($urandom_range(0, 255)));
                else
                begin
                    w = board.sync;
                    k = $urandom_range(1, 3);
                    if ($urandom_range(0, 1) == 1)
                    begin
                        for (int i = 0; i < k; i++)
                            send_byte(w[8*(3-i) +: 8]);
                    end
                    else
                    begin
                        for (int i = 4 - k; i < 4; i++)
                            send_byte(w[8*(3-i) +: 8]);
                    end
                    send_byte(sld_pkg::BYTE_W'($urandom_range(0, 255)));
                end
            end
        end

        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #(8 * 400000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
